### rtl/ittd_pkg.sv
// ----------------------------------------------------------------------------
// ittd_pkg
// Shared types and constants for the signed 64-bit to decimal text converter.
// ----------------------------------------------------------------------------
package ittd_pkg;

  // 2^63 has 19 decimal digits, so 19 bcd cells hold any magnitude
  localparam int NUM_DIGITS = 19;
  localparam int MAG_W      = 64;
  localparam int LEN_W      = 5;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_NONE  = 8'h00;

  localparam logic ST_OK        = 1'b0;
  localparam logic ST_TOO_SMALL = 1'b1;

  typedef struct packed {
    logic signed [63:0] value;
    logic [7:0]         buffer_size;
  } in_beat_t;

  typedef struct packed {
    logic [7:0]       character;
    logic [LEN_W-1:0] text_length;
    logic             status;
    logic             last;
  } out_beat_t;

  // control shared by every cell of the chain
  typedef struct packed {
    logic clear;
    logic shift;
  } cell_ctl_t;

endpackage

### rtl/int64_to_decimal_text.sv
// an item is converted by shifting its magnitude msb first through the bcd cell chain,
// then a length step sets the text length and the text goes out one beat per cycle
// while out_ready does not stall; a too small buffer gives a single error beat instead
// one item at a time; the next item is taken while the final beat waits in the output register
// reset (rst_n low, synchronous) returns the sequencer to idle and drops out_valid
// ----------------------------------------------------------------------------
// int64_to_decimal_text
// Signed 64-bit integer to decimal ascii text, most significant character first.
// ----------------------------------------------------------------------------
module int64_to_decimal_text (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  ittd_pkg::in_beat_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output ittd_pkg::out_beat_t out_data
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CONV,
    S_LEN,
    S_EMIT
  } state_t;

  localparam int ND = ittd_pkg::NUM_DIGITS;
  localparam int LW = ittd_pkg::LEN_W;

  state_t                      state_r;
  logic [ittd_pkg::MAG_W-1:0]  mag_r;
  logic [5:0]                  bit_cnt_r;
  logic                        neg_r;
  logic [7:0]                  size_r;
  logic [LW-1:0]               len_r;
  logic [LW-1:0]               pos_r;
  logic                        out_valid_r;
  ittd_pkg::out_beat_t         out_r;

  ittd_pkg::cell_ctl_t         cell_ctl;
  logic [ND:0]                 carry;
  logic [3:0]                  digits [ND];

  logic                        in_fire;
  logic                        out_free;
  logic [LW-1:0]               ndig;
  logic [LW-1:0]               dig_idx;
  logic [3:0]                  sel_digit;
  logic                        too_small;
  logic                        is_last;
  logic [7:0]                  emit_char;

  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  // cell chain control: clear on a new item, shift during conversion
  assign cell_ctl.clear = in_fire;
  assign cell_ctl.shift = (state_r == S_CONV);

  // magnitude enters the chain msb first at cell 0
  assign carry[0] = mag_r[ittd_pkg::MAG_W-1];

  for (genvar g = 0; g < ND; g++) begin : g_cell
    ittd_digit_cell u_cell (
      .clk      (clk),
      .ctl      (cell_ctl),
      .shift_in (carry[g]),
      .shift_out(carry[g+1]),
      .digit    (digits[g])
    );
  end

  // significant digit count: highest nonzero cell, at least one digit for zero
  always_comb begin
    ndig = LW'(1);
    for (int i = 0; i < ND; i++) begin
      if (digits[i] != 4'd0) begin
        ndig = LW'(i + 1);
      end
    end
  end

  // text position pos maps to digit len-1-pos counted from the least significant
  assign dig_idx = len_r - LW'(1) - pos_r;

  always_comb begin
    sel_digit = 4'd0;
    if (dig_idx < LW'(ND)) begin
      sel_digit = digits[dig_idx];
    end
  end

  // text plus terminator must fit the buffer
  assign too_small = (size_r <= {3'b000, len_r});
  assign is_last   = (pos_r == (len_r - LW'(1)));

  always_comb begin
    if (neg_r && (pos_r == '0)) begin
      emit_char = ittd_pkg::CHAR_MINUS;
    end else begin
      emit_char = ittd_pkg::CHAR_ZERO + {4'd0, sel_digit};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      // in the emit state the output register is handled below
      if (out_valid_r && out_ready && (state_r != S_EMIT)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            // two's complement magnitude; the most negative value maps to 2^63
            mag_r     <= in_data.value[63] ? (~in_data.value + 64'd1) : in_data.value;
            neg_r     <= in_data.value[63];
            size_r    <= in_data.buffer_size;
            bit_cnt_r <= 6'd63;
            state_r   <= S_CONV;
          end
        end
        S_CONV: begin
          mag_r     <= {mag_r[ittd_pkg::MAG_W-2:0], 1'b0};
          bit_cnt_r <= bit_cnt_r - 6'd1;
          if (bit_cnt_r == 6'd0) begin
            state_r <= S_LEN;
          end
        end
        S_LEN: begin
          len_r   <= ndig + LW'(neg_r);
          pos_r   <= '0;
          state_r <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            if (too_small) begin
              // single error beat in place of the text
              out_r.character   <= ittd_pkg::CHAR_NONE;
              out_r.text_length <= '0;
              out_r.status      <= ittd_pkg::ST_TOO_SMALL;
              out_r.last        <= 1'b1;
              state_r           <= S_IDLE;
            end else begin
              out_r.character   <= emit_char;
              out_r.text_length <= len_r;
              out_r.status      <= ittd_pkg::ST_OK;
              out_r.last        <= is_last;
              pos_r             <= pos_r + LW'(1);
              if (is_last) begin
                state_r <= S_IDLE;
              end
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // the top cell never overflows since every magnitude is below 10^19
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CONV) |-> !carry[ND])
    else $error("bcd chain overflow");

  // an error beat always closes its item
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_r.status == ittd_pkg::ST_TOO_SMALL)) |-> out_r.last)
    else $error("error beat without last");

  // text beats carry a digit or minus and a length within range
  a_ok_char: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_r.status == ittd_pkg::ST_OK)) |->
      ((out_r.character == ittd_pkg::CHAR_MINUS) ||
       ((out_r.character >= ittd_pkg::CHAR_ZERO) &&
        (out_r.character <= (ittd_pkg::CHAR_ZERO + 8'd9)))) &&
      (out_r.text_length != '0) && (out_r.text_length <= LW'(ND + 1)))
    else $error("bad text beat");

  // a new beat is only loaded into a free output register
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> ($stable(out_r) && out_valid_r))
    else $error("pending beat overwritten");

  // conversion always runs into the length step after the final shift
  a_conv_end: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_CONV) && (bit_cnt_r == 6'd0)) |=> (state_r == S_LEN))
    else $error("conversion did not end");

endmodule

### rtl/ittd_digit_cell.sv
// ----------------------------------------------------------------------------
// ittd_digit_cell
// One bcd digit of the shift-and-add-3 chain.
// ----------------------------------------------------------------------------
module ittd_digit_cell (
  input  logic                  clk,
  input  ittd_pkg::cell_ctl_t   ctl,
  input  logic                  shift_in,
  output logic                  shift_out,
  output logic [3:0]            digit
);

  logic [3:0] digit_r;
  logic [3:0] digit_nxt;
  logic [3:0] adj;

  // add 3 when the digit would reach ten or more after doubling
  always_comb begin
    adj = (digit_r >= 4'd5) ? (digit_r + 4'd3) : digit_r;
  end

  assign shift_out = adj[3];

  always_comb begin
    digit_nxt = digit_r;
    if (ctl.clear) begin
      digit_nxt = 4'd0;
    end else if (ctl.shift) begin
      digit_nxt = {adj[2:0], shift_in};
    end
  end

  always_ff @(posedge clk) begin
    digit_r <= digit_nxt;
  end

  assign digit = digit_r;

endmodule
